// File: hw/rtl/stti_pkg.sv
// Shared types and constants for the sorted trace table interpolator.
package stti_pkg;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_COMMIT = 3'd1;
    localparam logic [2:0] OP_QUERY  = 3'd2;
    localparam logic [2:0] OP_CHECK  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TOO_MANY = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_DUP     = 3'd4;
    localparam logic [2:0] ST_SIDE    = 3'd5;

    // serial divider operand widths
    localparam int DVD_W = 54;
    localparam int DVS_W = 21;

    typedef struct packed {
        logic        [2:0]  opcode;
        logic signed [19:0] key;
        logic signed [19:0] side_value;
        logic        [10:0] elem_count;
        logic        [9:0]  elem_index;
        logic signed [31:0] elem_value;
    } in_t;

    typedef struct packed {
        logic        [2:0]  status;
        logic signed [19:0] out_key;
        logic signed [19:0] out_side_value;
        logic        [10:0] out_count;
        logic signed [31:0] out_elem_value;
    } res_t;

endpackage

// File: hw/rtl/stti_div.sv
// Restoring serial divider, one quotient bit per cycle.
module stti_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [stti_pkg::DVD_W-1:0]  dividend,
    input  logic [stti_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [stti_pkg::DVD_W-1:0]  quotient
);

    localparam int CW = $clog2(stti_pkg::DVD_W + 1);

    logic [CW-1:0]               cnt_reg;
    logic [stti_pkg::DVS_W-1:0]  rem_reg;
    logic [stti_pkg::DVD_W-1:0]  quo_reg;
    logic [stti_pkg::DVS_W-1:0]  dvs_reg;
    logic                        done_reg;
    logic [stti_pkg::DVS_W:0]    trial;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[stti_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(stti_pkg::DVD_W);
                rem_reg <= '0;
                quo_reg <= dividend;
                dvs_reg <= divisor;
            end
            else if (cnt_reg != '0)
            begin
                rem_reg <= fits ? stti_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                                : stti_pkg::DVS_W'(trial);
                quo_reg <= {quo_reg[stti_pkg::DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> cnt_reg == '0) else $error("divider done while running");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && !start && dvs_reg != '0) |-> rem_reg < dvs_reg)
        else $error("remainder not below divisor");
`endif

endmodule

// File: hw/rtl/sorted_trace_table_interpolator.sv
// Top level: sorted record table with sequencer, element memory and interpolation.
// An item is taken when start is high and busy is low; busy stays high until its result
// appears on result with done high for one cycle, which the receiver must capture then.
// Load, clear and unused opcodes finish from the dispatch state; a commit walks the sorted
// order one entry per cycle and then shifts the order, and a check walks the order likewise;
// a query walks the order and then either copies a record or interpolates, the latter through
// two element memory reads, the multiply and the 54-step serial divider. The element memory
// has no reset and needs no clearing pass.
module sorted_trace_table_interpolator
#(
    parameter int TABLE_DEPTH = 16,
    parameter int MAX_ELEMS   = 1024
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  stti_pkg::in_t  cmd,
    output logic           busy,
    output logic           done,
    output stti_pkg::res_t result
);

    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int MD = TABLE_DEPTH * MAX_ELEMS;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_CWALK, S_CSHIFT, S_QWALK, S_QCOPY,
        S_QRD1, S_QRD2, S_QMUL, S_QSTART, S_QDIV, S_KWALK
    } state_t;

    state_t               state_reg;
    stti_pkg::in_t        cmd_reg;
    logic [NW-1:0]        total_reg;
    logic [SW-1:0]        i_reg;
    logic [NW-1:0]        pos_reg;
    logic signed [19:0]   prev_key_reg;
    logic signed [19:0]   prev_side_reg;
    logic [10:0]          prev_cnt_reg;
    logic [SW-1:0]        prev_slot_reg;
    logic [SW-1:0]        b_slot_reg;
    logic [10:0]          b_cnt_reg;
    logic signed [19:0]   side_out_reg;
    logic [10:0]          cnt_out_reg;
    logic                 v0_reg;
    logic                 v1_reg;
    logic signed [31:0]   e0_reg;
    logic signed [32:0]   diff_reg;
    logic signed [20:0]   dk_reg;
    logic [20:0]          den_reg;
    logic signed [53:0]   prod_reg;
    logic signed [19:0]   keys_reg  [TABLE_DEPTH];
    logic signed [19:0]   sides_reg [TABLE_DEPTH];
    logic [10:0]          cnts_reg  [TABLE_DEPTH];
    logic [SW-1:0]        ord_reg   [TABLE_DEPTH];
    stti_pkg::res_t       res_reg;
    logic                 done_reg;

    logic [31:0]          mem [MD];
    logic [31:0]          mem_rdata;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [SW-1:0]        rslot;

    logic [SW-1:0]        cur_slot;
    logic signed [19:0]   cur_key;
    logic signed [19:0]   cur_side;
    logic [10:0]          cur_cnt;
    logic                 first;
    logic                 last;
    logic                 q_interp;
    logic                 q_copy;
    logic                 div_start;
    logic                 div_done;
    logic [stti_pkg::DVD_W-1:0] div_quo;
    logic [stti_pkg::DVD_W-1:0] prod_mag;
    logic signed [33:0]   q_signed;
    logic signed [34:0]   interp_sum;
    logic signed [31:0]   e1_val;

    function automatic stti_pkg::res_t make_res(logic [2:0] st, logic signed [19:0] k,
                                                logic signed [19:0] s, logic [10:0] c,
                                                logic signed [31:0] e);
        stti_pkg::res_t r;
        r.status         = st;
        r.out_key        = k;
        r.out_side_value = s;
        r.out_count      = c;
        r.out_elem_value = e;
        return r;
    endfunction

    assign cur_slot = ord_reg[i_reg];
    assign cur_key  = keys_reg[cur_slot];
    assign cur_side = sides_reg[cur_slot];
    assign cur_cnt  = cnts_reg[cur_slot];
    assign first    = (i_reg == '0);
    assign last     = (NW'(i_reg) + NW'(1) == total_reg);
    assign q_interp = !first && (cmd_reg.key < cur_key);
    assign q_copy   = !q_interp && ((cmd_reg.key <= cur_key) || last);

    always_comb
    begin
        mem_we    = (state_reg == S_DISP) && (cmd_reg.opcode == stti_pkg::OP_LOAD)
                    && (total_reg < NW'(TABLE_DEPTH))
                    && (32'(cmd_reg.elem_index) < 32'(MAX_ELEMS));
        mem_waddr = AW'(AW'(total_reg[SW-1:0]) * AW'(MAX_ELEMS) + AW'(cmd_reg.elem_index));
        mem_re    = (state_reg == S_QRD1) || ((state_reg == S_QWALK) && (q_interp || q_copy));
        if (state_reg == S_QRD1)
            rslot = b_slot_reg;
        else if (q_interp)
            rslot = prev_slot_reg;
        else
            rslot = cur_slot;
        mem_raddr = AW'(AW'(rslot) * AW'(MAX_ELEMS) + AW'(cmd_reg.elem_index));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= cmd_reg.elem_value;
        if (mem_re)
            mem_rdata <= mem[mem_raddr];
    end

    assign div_start  = (state_reg == S_QSTART);
    assign prod_mag   = prod_reg[53] ? stti_pkg::DVD_W'(-prod_reg)
                                     : stti_pkg::DVD_W'(prod_reg);
    assign q_signed   = diff_reg[32] ? -$signed({1'b0, div_quo[32:0]})
                                     : $signed({1'b0, div_quo[32:0]});
    assign interp_sum = 35'(e0_reg) + 35'(q_signed);
    assign e1_val     = v1_reg ? $signed(mem_rdata) : 32'sd0;

    stti_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            total_reg     <= '0;
            i_reg         <= '0;
            pos_reg       <= '0;
            prev_key_reg  <= '0;
            prev_side_reg <= '0;
            prev_cnt_reg  <= '0;
            prev_slot_reg <= '0;
            b_slot_reg    <= '0;
            b_cnt_reg     <= '0;
            side_out_reg  <= '0;
            cnt_out_reg   <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            e0_reg        <= '0;
            diff_reg      <= '0;
            dk_reg        <= '0;
            den_reg       <= '0;
            prod_reg      <= '0;
            res_reg       <= '0;
            done_reg      <= 1'b0;
            for (int j = 0; j < TABLE_DEPTH; j++)
            begin
                keys_reg[j]  <= '0;
                sides_reg[j] <= '0;
                cnts_reg[j]  <= '0;
                ord_reg[j]   <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    i_reg <= '0;
                    priority case (cmd_reg.opcode)
                        stti_pkg::OP_LOAD:
                        begin
                            if (total_reg >= NW'(TABLE_DEPTH))
                                res_reg <= make_res(stti_pkg::ST_FULL, '0, '0, '0, '0);
                            else if (32'(cmd_reg.elem_index) >= 32'(MAX_ELEMS))
                                res_reg <= make_res(stti_pkg::ST_TOO_MANY, '0, '0, '0, '0);
                            else
                                res_reg <= make_res(stti_pkg::ST_OK, '0, '0, '0, '0);
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        stti_pkg::OP_COMMIT:
                        begin
                            if (32'(cmd_reg.elem_count) > 32'(MAX_ELEMS))
                            begin
                                res_reg   <= make_res(stti_pkg::ST_TOO_MANY, '0, '0, '0, '0);
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else if (total_reg >= NW'(TABLE_DEPTH))
                            begin
                                res_reg   <= make_res(stti_pkg::ST_FULL, '0, '0, '0, '0);
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                keys_reg[total_reg[SW-1:0]]  <= cmd_reg.key;
                                sides_reg[total_reg[SW-1:0]] <= cmd_reg.side_value;
                                cnts_reg[total_reg[SW-1:0]]  <= cmd_reg.elem_count;
                                pos_reg <= '0;
                                state_reg <= (total_reg == '0) ? S_CSHIFT : S_CWALK;
                            end
                        end
                        stti_pkg::OP_QUERY, stti_pkg::OP_CHECK:
                        begin
                            if (total_reg == '0)
                            begin
                                res_reg   <= make_res(stti_pkg::ST_EMPTY, '0, '0, '0, '0);
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                                state_reg <= (cmd_reg.opcode == stti_pkg::OP_QUERY)
                                             ? S_QWALK : S_KWALK;
                        end
                        stti_pkg::OP_CLEAR:
                        begin
                            total_reg <= '0;
                            res_reg   <= make_res(stti_pkg::ST_OK, '0, '0, '0, '0);
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        default:
                        begin
                            res_reg   <= make_res(stti_pkg::ST_OK, '0, '0, '0, '0);
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_CWALK:
                begin
                    if (cmd_reg.key <= cur_key)
                    begin
                        pos_reg   <= NW'(i_reg);
                        state_reg <= S_CSHIFT;
                    end
                    else if (last)
                    begin
                        pos_reg   <= total_reg;
                        state_reg <= S_CSHIFT;
                    end
                    else
                        i_reg <= i_reg + SW'(1);
                end
                S_CSHIFT:
                begin
                    for (int j = 0; j < TABLE_DEPTH; j++)
                    begin
                        if (NW'(j) == pos_reg)
                            ord_reg[j] <= total_reg[SW-1:0];
                        else if (j > 0 && NW'(j) > pos_reg && NW'(j) <= total_reg)
                            ord_reg[j] <= ord_reg[(j > 0) ? j - 1 : 0];
                    end
                    total_reg <= total_reg + NW'(1);
                    res_reg   <= make_res(stti_pkg::ST_OK, '0, '0, '0, '0);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_QWALK:
                begin
                    if (q_interp)
                    begin
                        b_slot_reg <= cur_slot;
                        b_cnt_reg  <= cur_cnt;
                        dk_reg     <= {cmd_reg.key[19], cmd_reg.key}
                                      - {prev_key_reg[19], prev_key_reg};
                        den_reg    <= 21'({cur_key[19], cur_key}
                                      - {prev_key_reg[19], prev_key_reg});
                        v0_reg     <= {1'b0, cmd_reg.elem_index} < prev_cnt_reg;
                        state_reg  <= S_QRD1;
                    end
                    else if (q_copy)
                    begin
                        side_out_reg <= cur_side;
                        cnt_out_reg  <= cur_cnt;
                        v0_reg       <= {1'b0, cmd_reg.elem_index} < cur_cnt;
                        state_reg    <= S_QCOPY;
                    end
                    else
                    begin
                        prev_slot_reg <= cur_slot;
                        prev_key_reg  <= cur_key;
                        prev_side_reg <= cur_side;
                        prev_cnt_reg  <= cur_cnt;
                        i_reg         <= i_reg + SW'(1);
                    end
                end
                S_QCOPY:
                begin
                    res_reg   <= make_res(stti_pkg::ST_OK, cmd_reg.key, side_out_reg,
                                          cnt_out_reg, v0_reg ? $signed(mem_rdata) : 32'sd0);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_QRD1:
                begin
                    e0_reg       <= v0_reg ? $signed(mem_rdata) : 32'sd0;
                    v1_reg       <= {1'b0, cmd_reg.elem_index} < b_cnt_reg;
                    side_out_reg <= prev_side_reg;
                    cnt_out_reg  <= (prev_cnt_reg >= b_cnt_reg) ? prev_cnt_reg : b_cnt_reg;
                    state_reg    <= S_QRD2;
                end
                S_QRD2:
                begin
                    diff_reg  <= 33'(e1_val) - 33'(e0_reg);
                    state_reg <= S_QMUL;
                end
                S_QMUL:
                begin
                    prod_reg  <= 54'(diff_reg) * 54'(dk_reg);
                    state_reg <= S_QSTART;
                end
                S_QSTART:
                begin
                    state_reg <= S_QDIV;
                end
                S_QDIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= make_res(stti_pkg::ST_OK, cmd_reg.key, side_out_reg,
                                              cnt_out_reg, interp_sum[31:0]);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_KWALK:
                begin
                    if (first)
                    begin
                        prev_key_reg  <= cur_key;
                        prev_side_reg <= cur_side;
                        if (last)
                        begin
                            res_reg   <= make_res(stti_pkg::ST_OK, '0, '0, '0, '0);
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                            i_reg <= i_reg + SW'(1);
                    end
                    else if (cur_key == prev_key_reg)
                    begin
                        res_reg   <= make_res(stti_pkg::ST_DUP, '0, '0, '0, '0);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (cur_side != prev_side_reg)
                    begin
                        res_reg   <= make_res(stti_pkg::ST_SIDE, '0, '0, '0, '0);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (last)
                    begin
                        res_reg   <= make_res(stti_pkg::ST_OK, '0, '0, '0, '0);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        prev_key_reg  <= cur_key;
                        prev_side_reg <= cur_side;
                        i_reg         <= i_reg + SW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("result strobe held");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE) else $error("result while busy");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("item accepted without going busy");
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= NW'(TABLE_DEPTH)) else $error("record total overflow");
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_QDIV) else $error("divider finished outside query");
`endif

endmodule
